[hdl/spn32_pkg.sv]
package spn32_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BoxW  = 64;
	localparam int unsigned CfgIdxW = 2;

	// Identity S-box, loaded at reset
	localparam logic [BoxW-1:0] SboxIdentity = 64'hFEDC_BA98_7654_3210;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_KEY      = 2'd0,
		CFG_SBOX_FWD = 2'd1,
		CFG_SBOX_INV = 2'd2
	} spn32_cfg_idx_t;

	// One transaction as it moves down the chain of round cells
	typedef struct packed {
		logic             vld;
		logic             op;
		logic [WordW-1:0] word;
	} spn32_xact_t;

	// Replace each of the eight nibbles through a 16-entry box
	function automatic logic [WordW-1:0] substitute(input logic [WordW-1:0] w,
			input logic [BoxW-1:0] box);
		logic [WordW-1:0] r;
		logic [3:0]       nib;
		r = '0;
		for (int n = 0; n < 8; n++) begin
			nib = w[4*n +: 4];
			r[4*n +: 4] = box[{nib, 2'b00} +: 4];
		end
		return r;
	endfunction

	// MSB-position i takes MSB-position (29*i+31) mod 32
	function automatic logic [WordW-1:0] permute_enc(input logic [WordW-1:0] w);
		logic [WordW-1:0] r;
		logic [4:0]       src;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			src = 5'((29 * i + 31) % 32);
			r[31-i] = w[5'd31 - src];
		end
		return r;
	endfunction

	// MSB-position i takes MSB-position 21*(i+1) mod 32
	function automatic logic [WordW-1:0] permute_dec(input logic [WordW-1:0] w);
		logic [WordW-1:0] r;
		logic [4:0]       src;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			src = 5'((21 * (i + 1)) % 32);
			r[31-i] = w[5'd31 - src];
		end
		return r;
	endfunction

endpackage

[hdl/spn32_round_cell.sv]
module spn32_round_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spn32_pkg::spn32_xact_t           xact_in,
	input  logic [spn32_pkg::WordW-1:0]      cipher_key,
	input  logic [spn32_pkg::BoxW-1:0]       sbox_forward,
	input  logic [spn32_pkg::BoxW-1:0]       sbox_inverse,
	output spn32_pkg::spn32_xact_t           xact_out
);
	import spn32_pkg::*;

	logic [WordW-1:0] enc_word;
	logic [WordW-1:0] dec_word;
	logic             vld_s1;
	logic             op_s1;
	logic [WordW-1:0] word_s1;

	// One round each way: key, S-box, permutation; reversed for decryption
	always_comb begin
		enc_word = permute_enc(substitute(xact_in.word ^ cipher_key, sbox_forward));
		dec_word = substitute(permute_dec(xact_in.word), sbox_inverse) ^ cipher_key;
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= xact_in.vld;
		end
	end

	// Advance the payload to the next cell
	always_ff @(posedge clk) begin
		op_s1   <= xact_in.op;
		word_s1 <= xact_in.op ? dec_word : enc_word;
	end

	assign xact_out = '{vld: vld_s1, op: op_s1, word: word_s1};

endmodule

[hdl/spn_block_cipher_32_unit.sv]
// Throughput: one transaction per cycle; busy stays low, so start may be high every cycle.
// Each round is one cell of a registered chain, plus an input and an output register.
// done is a one-cycle strobe; the receiver cannot stall, so nothing backs up.
// Reset clears the valid flags, the key to zero and both S-boxes to identity.
module spn_block_cipher_32_unit #(
	parameter int unsigned ROUNDS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [spn32_pkg::WordW-1:0]      block_in,
	output logic                             done,
	output logic [spn32_pkg::WordW-1:0]      block_out,
	input  logic                             cfg_we,
	input  logic [spn32_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [spn32_pkg::BoxW-1:0]       cfg_data
);
	import spn32_pkg::*;

	logic [WordW-1:0] cipher_key_q;
	logic [BoxW-1:0]  sbox_forward_q;
	logic [BoxW-1:0]  sbox_inverse_q;
	spn32_xact_t      stage [0:ROUNDS];
	logic             vld_s0;
	logic             op_s0;
	logic [WordW-1:0] word_s0;
	logic             done_q;
	logic [WordW-1:0] block_out_q;

	assign busy = 1'b0;

	// Write configuration registers; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q   <= '0;
			sbox_forward_q <= SboxIdentity;
			sbox_inverse_q <= SboxIdentity;
		end else if (cfg_we) begin
			case (spn32_cfg_idx_t'(cfg_index))
				CFG_KEY:      cipher_key_q   <= cfg_data[WordW-1:0];
				CFG_SBOX_FWD: sbox_forward_q <= cfg_data;
				CFG_SBOX_INV: sbox_inverse_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the transaction; decryption whitens with the key first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s0   <= op;
		word_s0 <= op ? (block_in ^ cipher_key_q) : block_in;
	end

	assign stage[0] = '{vld: vld_s0, op: op_s0, word: word_s0};

	// Chain of round cells
	for (genvar g = 0; g < ROUNDS; g++) begin : g_round
		spn32_round_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.xact_in      (stage[g]),
			.cipher_key   (cipher_key_q),
			.sbox_forward (sbox_forward_q),
			.sbox_inverse (sbox_inverse_q),
			.xact_out     (stage[g+1])
		);
	end

	// Register the result; encryption whitens with the key last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stage[ROUNDS].vld;
		end
	end

	always_ff @(posedge clk) begin
		block_out_q <= stage[ROUNDS].op ? stage[ROUNDS].word
			: (stage[ROUNDS].word ^ cipher_key_q);
	end

	assign done      = done_q;
	assign block_out = block_out_q;

`ifndef ASSERT_OFF
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ROUNDS + 2))
		else $error("result strobe without a matching accepted transaction");

	a_accept_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ROUNDS + 2) done)
		else $error("accepted transaction lost in the round chain");

	a_chain_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		stage[ROUNDS].vld |=> done)
		else $error("last round cell valid did not raise done");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a fully pipelined unit");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import spn32_pkg::*;

	localparam int unsigned NumRounds  = 4;
	localparam int unsigned Latency    = NumRounds + 2;
	localparam int unsigned CycleLimit = 50000;
	localparam int unsigned NumProbes  = 21;
	localparam int unsigned NumPhases  = 10;
	localparam int unsigned PhaseItems = 55;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

	typedef logic [WordW-1:0] word_t;
	typedef logic [BoxW-1:0]  box_t;

	localparam box_t BoxId   = SboxIdentity;
	localparam box_t BoxZero = '0;
	localparam box_t BoxOnes = '1;
	// entry n is 15-n: a bijection that is its own inverse
	localparam box_t BoxRev  = 64'h0123_4567_89AB_CDEF;

	typedef struct packed {
		logic  reload;
		logic  stray;
		word_t key;
		box_t  fwd;
		box_t  inv;
		logic  op;
		word_t word;
		logic  known;
		word_t result;
	} probe_t;

	// Directed transactions; a row with reload set first loads its key and boxes
	localparam probe_t Probes [NumProbes] = '{
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'h8000_0000, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'h0000_0001, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h8000_0000, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h0000_0001, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'h1234_5678, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h1234_5678, 1'b0, 32'h0},
		// unknown register index written with all ones must change nothing
		'{1'b1, 1'b1, 32'h0, BoxId, BoxId, OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		// all-ones key with all-zero boxes: every word maps to all ones
		'{1'b1, 1'b0, 32'hFFFF_FFFF, BoxZero, BoxZero, OP_ENCRYPT, 32'h0, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'hA5A5_A5A5, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h5A5A_5A5A, 1'b1, 32'hFFFF_FFFF},
		// forward box all ones, inverse set to identity: boxes disagree
		'{1'b1, 1'b0, 32'h0, BoxOnes, BoxId, OP_ENCRYPT, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'hDEAD_BEEF, 1'b0, 32'h0},
		'{1'b1, 1'b0, 32'hC3A5_0F96, BoxRev, BoxRev, OP_ENCRYPT, 32'h1357_9BDF, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_DECRYPT, 32'h2468_ACE0, 1'b0, 32'h0},
		'{1'b0, 1'b0, 32'h0, BoxZero, BoxZero, OP_ENCRYPT, 32'hFFFF_FFFF, 1'b0, 32'h0}
	};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                op;
	word_t               block_in;
	logic                done;
	word_t               block_out;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	box_t                cfg_data;

	// Shadow of the configuration registers
	word_t key_copy;
	box_t  fwd_box;
	box_t  inv_box;

	word_t       expected_blocks [$];
	int unsigned error_count;
	int unsigned cycle_count;
	bit          gaps_on;

	spn_block_cipher_32_unit #(
		.ROUNDS(NumRounds)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.op       (op),
		.block_in (block_in),
		.done     (done),
		.block_out(block_out),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Replace each nibble by the box entry it selects
	function automatic word_t nibble_sub(word_t w, box_t box);
		word_t       r;
		int unsigned sel;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			sel = w[4*k +: 4];
			r[4*k +: 4] = box[4*sel +: 4];
		end
		return r;
	endfunction

	// Bit position p from the MSB takes position (mul*p+add) mod 32
	function automatic word_t bit_shuffle(word_t w, int unsigned mul, int unsigned add);
		word_t       r;
		int unsigned src;
		r = '0;
		for (int p = 0; p < 32; p++) begin
			src = (mul * p + add) % 32;
			r[31-p] = w[31-src];
		end
		return r;
	endfunction

	// Work out the block the cipher gives under the current settings
	function automatic word_t spn_transform(logic dir, word_t w);
		word_t x;
		x = w;
		if (dir == OP_ENCRYPT) begin
			for (int r = 0; r < NumRounds; r++) begin
				x = nibble_sub(x ^ key_copy, fwd_box);
				x = bit_shuffle(x, 29, 31);
			end
			x = x ^ key_copy;
		end else begin
			x = x ^ key_copy;
			for (int r = 0; r < NumRounds; r++) begin
				x = bit_shuffle(x, 21, 21);
				x = nibble_sub(x, inv_box) ^ key_copy;
			end
		end
		return x;
	endfunction

	// Random bijective S-box by an in-place shuffle
	function automatic box_t shuffled_box();
		int unsigned perm [16];
		int unsigned j;
		int unsigned t;
		box_t        b;
		for (int i = 0; i < 16; i++)
			perm[i] = i;
		for (int i = 15; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < 16; i++)
			b[4*i +: 4] = 4'(perm[i]);
		return b;
	endfunction

	function automatic box_t invert_box(box_t b);
		box_t        r;
		int unsigned v;
		r = '0;
		for (int n = 0; n < 16; n++) begin
			v = b[4*n +: 4];
			r[4*v +: 4] = 4'(n);
		end
		return r;
	endfunction

	// Mostly random words, with extremes and single-bit patterns mixed in
	function automatic word_t pick_word();
		word_t w;
		case ($urandom_range(9))
			0: w = '0;
			1: w = '1;
			2: w = word_t'(1) << $urandom_range(31);
			3: w = ~(word_t'(1) << $urandom_range(31));
			default: w = $urandom();
		endcase
		return w;
	endfunction

	// Hold start low until every outstanding block has come back
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_blocks.size() != 0);
	endtask

	task automatic cfg_put(logic [CfgIdxW-1:0] idx, box_t data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_KEY:      key_copy = data[WordW-1:0];
			CFG_SBOX_FWD: fwd_box = data;
			CFG_SBOX_INV: inv_box = data;
			default: ;
		endcase
	endtask

	// Load key and boxes while idle; optionally poke the unused index afterwards
	task automatic reconfigure(logic stray, word_t key, box_t fwd, box_t inv, box_t junk);
		word_t upper;
		upper = $urandom();
		drain();
		cfg_put(CFG_KEY, {upper, key});
		cfg_put(CFG_SBOX_FWD, fwd);
		cfg_put(CFG_SBOX_INV, inv);
		if (stray)
			cfg_put(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
	endtask

	// Offer one transaction and record its expected block once accepted
	task automatic send_block(logic dir, word_t w, logic known, word_t result);
		while (gaps_on && $urandom_range(99) < 15) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		op       <= dir;
		block_in <= w;
		do
			@(posedge clk);
		while (busy);
		expected_blocks.push_back(known ? result : spn_transform(dir, w));
	endtask

	// Check each result against the oldest expected block
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_blocks.size() == 0) begin
				$error("block_out: no transaction outstanding, got %h", block_out);
				error_count++;
			end else if (block_out !== expected_blocks[0]) begin
				$error("block_out: expected %h, got %h", expected_blocks[0], block_out);
				error_count++;
				void'(expected_blocks.pop_front());
			end else begin
				void'(expected_blocks.pop_front());
			end
		end
	end

	// Guard against a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		word_t       key;
		word_t       w;
		word_t       ct;
		box_t        fwd;
		box_t        inv;
		int unsigned n;
		bit          held;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		op        <= OP_ENCRYPT;
		block_in  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_KEY;
		cfg_data  <= '0;
		key_copy    = '0;
		fwd_box     = SboxIdentity;
		inv_box     = SboxIdentity;
		error_count = 0;
		cycle_count = 0;
		gaps_on     = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		for (int i = 0; i < NumProbes; i++) begin
			if (Probes[i].reload)
				reconfigure(Probes[i].stray, Probes[i].key, Probes[i].fwd, Probes[i].inv, BoxOnes);
			send_block(Probes[i].op, Probes[i].word, Probes[i].known, Probes[i].result);
		end

		// Random part: a new setting per phase, mostly encrypt/decrypt round trips
		for (int ph = 0; ph < NumPhases; ph++) begin
			case ($urandom_range(9))
				0: key = '0;
				1: key = '1;
				default: key = $urandom();
			endcase
			fwd = shuffled_box();
			case ($urandom_range(9))
				7: begin
					fwd = {$urandom(), $urandom()};
					inv = {$urandom(), $urandom()};
				end
				8: inv = shuffled_box();
				9: inv = fwd;
				default: inv = invert_box(fwd);
			endcase
			reconfigure($urandom_range(3) == 0, key, fwd, inv, {$urandom(), $urandom()});
			// keep one phase free of gaps so the pipeline runs back to back
			gaps_on = (ph != 3);
			held = 1'b0;
			n = 0;
			while (n < PhaseItems) begin
				if (ph == 6 && !held && n >= PhaseItems / 2) begin
					drain();
					held = 1'b1;
				end
				if ($urandom_range(9) < 6) begin
					w  = pick_word();
					ct = spn_transform(OP_ENCRYPT, w);
					send_block(OP_ENCRYPT, w, 1'b0, '0);
					send_block(OP_DECRYPT, ct, 1'b0, '0);
					n += 2;
				end else begin
					send_block(1'($urandom_range(1)), pick_word(), 1'b0, '0);
					n++;
				end
			end
		end

		// Let the pipeline empty, then report
		start <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (Latency + 4) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hdl/spn32_pkg.sv
hdl/spn32_round_cell.sv
hdl/spn_block_cipher_32_unit.sv
tb/testbench.sv
